@@ hw/rtl/lpr_pkg.sv @@
// shared constants, types and result codes for the lru page replacement block
package lpr_pkg;

   localparam int PAGE_TOTAL  = 64;
   localparam int FRAME_TOTAL = 16;

   localparam int PAGE_W    = $clog2(PAGE_TOTAL);
   localparam int FRAME_W   = $clog2(FRAME_TOTAL);
   localparam int COUNT_W   = $clog2(FRAME_TOTAL + 1);
   localparam int LIMIT_W   = 5;
   localparam int OUTCOME_W = 2;

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [LIMIT_W-1:0] limit_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_HIT     = 2'd0,
      OUTCOME_FREE    = 2'd1,
      OUTCOME_REPLACE = 2'd2
   } outcome_type;

   typedef struct packed {
      outcome_type outcome;
      frame_type   frame;
      page_type    evict_page;
      logic        victim_valid;
   } result_type;

endpackage

@@ hw/rtl/lpr_core.sv @@
// frame table: owner lookup, lru selection and recency rank update
module lpr_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  lpr_pkg::page_type  page,
   input  lpr_pkg::limit_type frame_limit,
   output lpr_pkg::result_type result
);
   import lpr_pkg::*;

   page_type  owner_ff [FRAME_TOTAL];
   page_type  owner_in [FRAME_TOTAL];
   frame_type rank_ff  [FRAME_TOTAL];
   frame_type rank_in  [FRAME_TOTAL];
   count_type used_ff;
   count_type used_in;

   logic [FRAME_TOTAL-1:0] used_mask;
   logic [FRAME_TOTAL-1:0] match_vec;
   logic [FRAME_TOTAL-1:0] lru_vec;
   logic [FRAME_TOTAL-1:0] free_vec;
   logic [FRAME_TOTAL-1:0] target_vec;
   count_type              eff_limit;
   count_type              used_m1;
   logic                   hit;
   logic                   free_miss;
   logic                   age_all;
   frame_type              hit_frame;
   frame_type              lru_frame;
   frame_type              limit_rank;
   page_type               victim;

   // clamp the limit into 1..FRAME_TOTAL
   always_comb begin
      priority if (frame_limit == '0) begin
         eff_limit = COUNT_W'(1);
      end else if (int'(frame_limit) > FRAME_TOTAL) begin
         eff_limit = COUNT_W'(FRAME_TOTAL);
      end else begin
         eff_limit = COUNT_W'(frame_limit);
      end
   end

   assign used_m1 = used_ff - COUNT_W'(1);

   // ranks of frames in use form a permutation of 0..used-1
   always_comb begin
      hit_frame  = '0;
      lru_frame  = '0;
      victim     = '0;
      for (int i = 0; i < FRAME_TOTAL; i++) begin
         used_mask[i] = (COUNT_W'(i) < used_ff);
         match_vec[i] = used_mask[i] && (owner_ff[i] == page);
         lru_vec[i]   = used_mask[i] && (rank_ff[i] == used_m1[FRAME_W-1:0]);
         free_vec[i]  = (COUNT_W'(i) == used_ff);
         if (match_vec[i]) begin
            hit_frame = hit_frame | FRAME_W'(i);
         end
         if (lru_vec[i]) begin
            lru_frame = lru_frame | FRAME_W'(i);
            victim    = victim | owner_ff[i];
         end
      end
   end

   assign hit       = |match_vec;
   assign free_miss = !hit && (used_ff < eff_limit);
   assign age_all   = free_miss;

   always_comb begin
      result = '0;
      priority if (hit) begin
         result.outcome = OUTCOME_HIT;
         result.frame   = hit_frame;
         target_vec     = match_vec;
      end else if (free_miss) begin
         result.outcome = OUTCOME_FREE;
         result.frame   = used_ff[FRAME_W-1:0];
         target_vec     = free_vec;
      end else begin
         result.outcome      = OUTCOME_REPLACE;
         result.frame        = lru_frame;
         result.evict_page   = victim;
         result.victim_valid = 1'b1;
         target_vec          = lru_vec;
      end
   end

   always_comb begin
      limit_rank = '0;
      for (int i = 0; i < FRAME_TOTAL; i++) begin
         if (target_vec[i]) begin
            limit_rank = limit_rank | rank_ff[i];
         end
      end
   end

   // promote the target frame, age the more recent ones
   always_comb begin
      for (int i = 0; i < FRAME_TOTAL; i++) begin
         rank_in[i]  = rank_ff[i];
         owner_in[i] = owner_ff[i];
         if (fire) begin
            if (target_vec[i]) begin
               rank_in[i] = '0;
               if (!hit) begin
                  owner_in[i] = page;
               end
            end else if (used_mask[i] && (age_all || (rank_ff[i] < limit_rank))) begin
               rank_in[i] = rank_ff[i] + FRAME_W'(1);
            end
         end
      end
      used_in = (fire && free_miss) ? used_ff + COUNT_W'(1) : used_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int i = 0; i < FRAME_TOTAL; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         used_ff <= used_in;
         for (int i = 0; i < FRAME_TOTAL; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_TOTAL; i++) begin
         owner_ff[i] <= owner_in[i];
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= FRAME_TOTAL)
      else $error("frame count above frame total");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page owns more than one frame");

   a_lru_unique: assert property (@(posedge clock) disable iff (reset)
      fire && (result.outcome == OUTCOME_REPLACE) |-> $onehot(lru_vec))
      else $error("no single least recent frame on replacement");

   a_free_count: assert property (@(posedge clock) disable iff (reset)
      fire && (result.outcome == OUTCOME_FREE) |=> used_ff == $past(used_ff) + COUNT_W'(1))
      else $error("frame count did not advance on free fault");

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
// lru page replacement top level: handshakes, frame limit register and result register
//
// Takes one page reference per cycle while req_stall is low and returns one result
// per reference: hit, fault into a free frame, or fault with replacement of the
// least recently used frame, with the frame now holding the page and the evicted
// page. The owner lookup, the least recent frame selection and the recency rank
// update all run combinationally from the frame table flops between the request
// register and the response register, so throughput is one reference per clock
// when nothing stalls. While a response is stalled one more request can be taken,
// then req_stall rises. The user must write csr_frame_limit (0 acts as 1, values
// above 16 act as 16) only while no transaction is in flight; the block does not
// enforce this. Lowering it does not release frames already in use.
module lru_page_replacement (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lpr_pkg::page_type   req_page,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_outcome,
   output lpr_pkg::frame_type  rsp_frame,
   output lpr_pkg::page_type   rsp_evict_page,
   output logic                rsp_victim_valid,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  lpr_pkg::limit_type  csr_frame_limit
);
   import lpr_pkg::*;

   logic       pipe_valid_ff;
   logic       pipe_valid_in;
   page_type   page_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type core_result;
   limit_type  limit_ff;
   logic       accept;
   logic       advance;

   assign advance   = pipe_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pipe_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign pipe_valid_in = accept || (pipe_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   lpr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .page        (page_ff),
      .frame_limit (limit_ff),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= LIMIT_W'(FRAME_TOTAL);
      end else begin
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_frame_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_ff.outcome;
   assign rsp_frame        = rsp_ff.frame;
   assign rsp_evict_page   = rsp_ff.evict_page;
   assign rsp_victim_valid = rsp_ff.victim_valid;

endmodule
